### rtl/swnr_pkg.sv
`timescale 1ns / 1ps

package swnr_pkg;

    // Block geometry
    localparam int VALUE_BOUND = 50;
    // Power of two: store addresses wrap by truncation
    localparam int WINDOW_MAX  = 256;
    localparam int COUNT_MAX   = 511;

    localparam int SAMPLE_W  = 7;
    localparam int CFG_W     = 9;
    localparam int CNT_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int BIN_W     = $clog2(VALUE_BOUND);
    localparam int STORE_AW  = $clog2(WINDOW_MAX);
    localparam int SEEN_W    = $clog2(VALUE_BOUND * COUNT_MAX + 1);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [CNT_W-1:0]           t_count;
    typedef logic [BIN_W-1:0]           t_bin;
    typedef logic [STORE_AW-1:0]        t_saddr;
    typedef logic [CFG_W-1:0]           t_cfg;
    typedef logic [SEEN_W-1:0]          t_seen;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LENGTH = 1'b0,
        CFG_RANK          = 1'b1
    } t_cfg_idx;

    localparam t_bin    LAST_BIN  = t_bin'(VALUE_BOUND - 1);
    localparam t_count  COUNT_TOP = t_count'(COUNT_MAX);
    localparam t_sample SAMPLE_HI = t_sample'(VALUE_BOUND);
    localparam t_sample SAMPLE_LO = t_sample'(-VALUE_BOUND);

    // Histogram port: one registered read, one write per cycle
    typedef struct packed {
        logic   rd_en;
        t_bin   rd_addr;
        logic   wr_en;
        t_bin   wr_addr;
        t_count wr_data;
    } t_hist_req;

    // Window store port
    typedef struct packed {
        logic    rd_en;
        t_saddr  rd_addr;
        logic    wr_en;
        t_saddr  wr_addr;
        t_sample wr_data;
    } t_store_req;

    // Bin of a negative sample: -VALUE_BOUND maps to bin 0
    function automatic t_bin bin_of(input t_sample s);
        logic [SAMPLE_W:0] w;
        w = {s[SAMPLE_W-1], s} + (SAMPLE_W+1)'(VALUE_BOUND);
        return w[BIN_W-1:0];
    endfunction

    // Sample value that a bin stands for
    function automatic t_sample bin_value(input t_bin b);
        logic [SAMPLE_W-1:0] w;
        w = SAMPLE_W'(b) - SAMPLE_W'(VALUE_BOUND);
        return t_sample'(w);
    endfunction

endpackage

### rtl/swnr_hist.sv
`timescale 1ns / 1ps

module swnr_hist (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  swnr_pkg::t_hist_req   i_req,
    output swnr_pkg::t_count      o_rd_data
);
    import swnr_pkg::*;

    t_count                 r_mem [VALUE_BOUND];
    logic [VALUE_BOUND-1:0] r_vld;
    t_count                 r_rdata;
    logic                   r_rvld;

    // Count memory
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.rd_addr];
        end
    end

    // Per-bin valid bits: a bin never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rvld <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rvld ? r_rdata : '0;

endmodule

### rtl/swnr_store.sv
`timescale 1ns / 1ps

module swnr_store (
    input  logic                  i_clk,
    input  swnr_pkg::t_store_req  i_req,
    output swnr_pkg::t_sample     o_rd_data
);
    import swnr_pkg::*;

    t_sample r_mem [WINDOW_MAX];
    t_sample r_rdata;

    // Circular delay line of clamped samples
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rdata;

endmodule

### rtl/sliding_window_negative_rank.sv
`timescale 1ns / 1ps

// Sliding-window rank filter over negative samples. Each input beat is clamped
// to +/-50, pushed into a 256-deep circular store and counted in a 50-bin
// histogram of negative values. Once the window holds window_length samples,
// every beat yields one output beat: the rank-th smallest window value if it
// is negative, else zero; the first window_length-1 beats yield nothing. A
// beat with no result is inserted and retired; one with a result is inserted,
// the histogram is scanned bin by bin from -50 up to the rank or the last bin,
// the oldest sample is removed and the beat retires. The histogram's single
// read port sets the scan time. A finished result waits in an output register
// while the next beat is taken. The user must write registers only while idle
// (not enforced by the block); they take effect on the next beat. Reset clears
// the histogram at once; a new sequence needs reset.
module sliding_window_negative_rank (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port
    input  logic                 i_cfg_we,
    input  swnr_pkg::t_cfg_idx   i_cfg_idx,
    input  swnr_pkg::t_cfg       i_cfg_data,
    // Sample channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  swnr_pkg::t_sample    i_sample,
    // Result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output swnr_pkg::t_sample    o_beauty
);
    import swnr_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_INS_RD   = 8'b0000_0010,
        S_INS_WR   = 8'b0000_0100,
        S_SCAN     = 8'b0000_1000,
        S_RM_STORE = 8'b0001_0000,
        S_RM_HIST  = 8'b0010_0000,
        S_RM_WR    = 8'b0100_0000,
        S_FIN      = 8'b1000_0000
    } t_state;

    t_state     r_state, n_state;
    t_cfg       r_wlen, n_wlen;
    t_cfg       r_rank, n_rank;
    t_saddr     r_wp, n_wp;
    t_saddr     r_fill, n_fill;
    t_sample    r_s, n_s;
    t_bin       r_addr, n_addr;
    t_bin       r_rd_bin, n_rd_bin;
    logic       r_rd_vld, n_rd_vld;
    t_seen      r_seen, n_seen;
    t_sample    r_res, n_res;
    logic       r_have_res, n_have_res;
    t_bin       r_old_bin, n_old_bin;
    logic       r_old_neg, n_old_neg;
    logic       r_out_valid, n_out_valid;
    t_sample    r_beauty, n_beauty;

    t_hist_req  hist_req;
    t_count     hist_q;
    t_store_req store_req;
    t_sample    store_q;

    logic       in_accept;
    t_sample    s_clamped;
    t_saddr     wlm1;
    t_cfg       need;
    t_seen      sum;
    t_sample    old_s;

    swnr_hist u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (hist_req),
        .o_rd_data (hist_q)
    );

    swnr_store u_store (
        .i_clk     (i_clk),
        .i_req     (store_req),
        .o_rd_data (store_q)
    );

    assign in_accept = i_in_valid && (r_state == S_IDLE);

    // Input clamp
    always_comb begin
        priority if (i_sample < SAMPLE_LO) begin
            s_clamped = SAMPLE_LO;
        end else if (i_sample > SAMPLE_HI) begin
            s_clamped = SAMPLE_HI;
        end else begin
            s_clamped = i_sample;
        end
    end

    // Effective window length minus one, and effective rank
    always_comb begin
        priority if (r_wlen == '0) begin
            wlm1 = '0;
        end else if (32'(r_wlen) > WINDOW_MAX) begin
            wlm1 = t_saddr'(WINDOW_MAX - 1);
        end else begin
            wlm1 = t_saddr'(r_wlen - t_cfg'(1));
        end
        need = (r_rank == '0) ? t_cfg'(1) : r_rank;
    end

    assign sum   = r_seen + SEEN_W'(hist_q);
    assign old_s = store_q;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_wlen      = r_wlen;
        n_rank      = r_rank;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_s         = r_s;
        n_addr      = r_addr;
        n_rd_bin    = r_rd_bin;
        n_rd_vld    = r_rd_vld;
        n_seen      = r_seen;
        n_res       = r_res;
        n_have_res  = r_have_res;
        n_old_bin   = r_old_bin;
        n_old_neg   = r_old_neg;
        n_beauty    = r_beauty;
        n_out_valid = r_out_valid && i_out_stall;

        hist_req  = '0;
        store_req = '0;

        // Configuration writes
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW_LENGTH: n_wlen = i_cfg_data;
                CFG_RANK:          n_rank = i_cfg_data;
                default:           n_wlen = r_wlen;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    store_req.wr_en   = 1'b1;
                    store_req.wr_addr = r_wp;
                    store_req.wr_data = s_clamped;
                    n_s               = s_clamped;
                    n_state           = S_INS_RD;
                end
            end
            S_INS_RD: begin
                // Only negative samples have a bin
                hist_req.rd_en   = r_s[SAMPLE_W-1];
                hist_req.rd_addr = bin_of(r_s);
                n_state          = S_INS_WR;
            end
            S_INS_WR: begin
                // Saturating increment of the new sample's bin
                if (r_s[SAMPLE_W-1] && hist_q != COUNT_TOP) begin
                    hist_req.wr_en   = 1'b1;
                    hist_req.wr_addr = bin_of(r_s);
                    hist_req.wr_data = hist_q + t_count'(1);
                end
                n_addr   = '0;
                n_rd_vld = 1'b0;
                n_seen   = '0;
                n_res    = '0;
                if (r_fill >= wlm1) begin
                    n_have_res = 1'b1;
                    n_state    = S_SCAN;
                end else begin
                    n_have_res = 1'b0;
                    n_state    = S_FIN;
                end
            end
            S_SCAN: begin
                // Read one bin per cycle, accumulate the one read last cycle
                hist_req.rd_en   = 1'b1;
                hist_req.rd_addr = r_addr;
                n_rd_bin         = r_addr;
                n_rd_vld         = 1'b1;
                if (r_addr != LAST_BIN) begin
                    n_addr = r_addr + t_bin'(1);
                end
                if (r_rd_vld) begin
                    n_seen = sum;
                    if (sum >= SEEN_W'(need)) begin
                        n_res   = bin_value(r_rd_bin);
                        n_state = S_RM_STORE;
                    end else if (r_rd_bin == LAST_BIN) begin
                        n_res   = '0;
                        n_state = S_RM_STORE;
                    end
                end
            end
            S_RM_STORE: begin
                store_req.rd_en   = 1'b1;
                store_req.rd_addr = r_wp - wlm1;
                n_state           = S_RM_HIST;
            end
            S_RM_HIST: begin
                hist_req.rd_en   = old_s[SAMPLE_W-1];
                hist_req.rd_addr = bin_of(old_s);
                n_old_bin        = bin_of(old_s);
                n_old_neg        = old_s[SAMPLE_W-1];
                n_state          = S_RM_WR;
            end
            S_RM_WR: begin
                // Decrement the leaving sample's bin, floor at zero
                if (r_old_neg && hist_q != '0) begin
                    hist_req.wr_en   = 1'b1;
                    hist_req.wr_addr = r_old_bin;
                    hist_req.wr_data = hist_q - t_count'(1);
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                // Retire once the output register can take the result
                if (!r_have_res || !r_out_valid || !i_out_stall) begin
                    if (r_have_res) begin
                        n_out_valid = 1'b1;
                        n_beauty    = r_res;
                    end
                    if (r_fill != t_saddr'(WINDOW_MAX - 1)) begin
                        n_fill = r_fill + t_saddr'(1);
                    end
                    n_wp    = r_wp + t_saddr'(1);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wlen      <= t_cfg'(1);
            r_rank      <= t_cfg'(1);
            r_wp        <= '0;
            r_fill      <= '0;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_have_res  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wlen      <= n_wlen;
            r_rank      <= n_rank;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_addr      <= n_addr;
            r_rd_vld    <= n_rd_vld;
            r_have_res  <= n_have_res;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_s       <= n_s;
        r_rd_bin  <= n_rd_bin;
        r_seen    <= n_seen;
        r_res     <= n_res;
        r_old_bin <= n_old_bin;
        r_old_neg <= n_old_neg;
        r_beauty  <= n_beauty;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_beauty    = r_beauty;

    // Checks
    a_result_not_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_beauty[SAMPLE_W-1] || o_beauty == '0))
        else $error("result beat carries a positive value");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr <= LAST_BIN))
        else $error("scan address past the last bin");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block not busy after taking a sample");

    a_result_only_at_retire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid && !$past(o_out_valid) && o_out_valid == 1'b0) ||
        !$rose(o_out_valid) || $past(r_state == S_FIN))
        else $error("result beat raised outside retire");

endmodule

### tb/rank_filter_checker.sv
`timescale 1ns / 1ps

// Watches the config port and both channels, predicts the beauty of every
// sample beat that yields a result and compares it with what the block sends out.
module rank_filter_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  swnr_pkg::t_cfg_idx  i_cfg_idx,
    input  swnr_pkg::t_cfg      i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  swnr_pkg::t_sample   i_sample,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  swnr_pkg::t_sample   i_beauty,
    output int                  o_fail_count,
    output int                  o_pending
);
    import swnr_pkg::*;

    // Mirror of the block state
    t_count  neg_hist [VALUE_BOUND];
    t_sample win_store [WINDOW_MAX];
    t_saddr  wr_pos;
    t_cfg    fill_cnt;
    t_cfg    win_len_cfg;
    t_cfg    rank_cfg;

    // Expected beauty values, oldest first
    t_sample beauty_q [$];
    t_sample want_beauty;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Insert a sample; on a full window yield rank-th smallest negative, drop oldest
    task automatic apply_sample_beat(input t_sample raw);
        int     v;
        int     wl;
        int     need;
        int     seen;
        int     res;
        int     old_v;
        int     b;
        bit     found;
        t_saddr oldest;
        v = int'(raw);
        if (v < -VALUE_BOUND) v = -VALUE_BOUND;
        if (v > VALUE_BOUND)  v = VALUE_BOUND;
        wl = int'(win_len_cfg);
        if (wl < 1)          wl = 1;
        if (wl > WINDOW_MAX) wl = WINDOW_MAX;
        need = int'(rank_cfg);
        if (need < 1) need = 1;

        win_store[wr_pos] = t_sample'(v);
        if (v < 0 && neg_hist[v + VALUE_BOUND] < COUNT_TOP)
            neg_hist[v + VALUE_BOUND] = neg_hist[v + VALUE_BOUND] + 1'b1;

        if (int'(fill_cnt) >= wl - 1) begin
            seen  = 0;
            res   = 0;
            found = 1'b0;
            // scan from the most negative bin upward
            for (b = 0; b < VALUE_BOUND; b++) begin
                seen += int'(neg_hist[b]);
                if (!found && seen >= need) begin
                    res   = b - VALUE_BOUND;
                    found = 1'b1;
                end
            end
            beauty_q.push_back(t_sample'(res));

            oldest = t_saddr'(int'(wr_pos) + WINDOW_MAX - (wl - 1));
            old_v  = int'(win_store[oldest]);
            // empty bin stays empty
            if (old_v < 0 && neg_hist[old_v + VALUE_BOUND] != '0)
                neg_hist[old_v + VALUE_BOUND] = neg_hist[old_v + VALUE_BOUND] - 1'b1;
        end

        if (int'(fill_cnt) < WINDOW_MAX - 1) fill_cnt = fill_cnt + 1'b1;
        wr_pos = wr_pos + 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VALUE_BOUND; i++) neg_hist[i] = '0;
            for (int i = 0; i < WINDOW_MAX; i++) win_store[i] = '0;
            wr_pos      = '0;
            fill_cnt    = '0;
            win_len_cfg = t_cfg'(1);
            rank_cfg    = t_cfg'(1);
            beauty_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WINDOW_LENGTH: win_len_cfg = i_cfg_data;
                    CFG_RANK:          rank_cfg    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                apply_sample_beat(i_sample);
            // result beat against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (beauty_q.size() == 0) begin
                    $error("beauty: no beat expected, actual %0d", i_beauty);
                    o_fail_count++;
                end else begin
                    want_beauty = beauty_q.pop_front();
                    if (i_beauty !== want_beauty) begin
                        $error("beauty: expected %0d, actual %0d", want_beauty, i_beauty);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = beauty_q.size();
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import swnr_pkg::*;

    // Idle time after the last result before a config write or the verdict
    localparam int SETTLE_CYCLES = 64;

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    t_cfg_idx cfg_idx;
    t_cfg     cfg_data;
    logic     in_valid;
    logic     in_stall;
    t_sample  sample;
    logic     out_valid;
    logic     out_stall;
    t_sample  beauty;
    int       fail_count;
    int       pending;

    sliding_window_negative_rank u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_sample    (sample),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_beauty    (beauty)
    );

    rank_filter_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_sample     (sample),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_beauty     (beauty),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog
    initial begin
        #1_500_000;
        $display("Mismatches found");
        $finish;
    end

    // Receiver stall pattern: modes of random length
    initial begin : receiver
        int mode;
        int span;
        out_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(negedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: if ($urandom_range(0, 15) == 0) out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // Hold one sample beat until accepted; returns at the next falling edge
    task automatic put_sample(input t_sample s);
        in_valid <= 1'b1;
        sample   <= s;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic stop_sender;
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Wait for every expected beat, then let the block go idle
    task automatic drain;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_config(input t_cfg wl, input t_cfg rk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WINDOW_LENGTH;
        cfg_data <= wl;
        @(negedge clk);
        cfg_idx  <= CFG_RANK;
        cfg_data <= rk;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Mostly in-range samples biased negative, a few raw 7-bit codes
    function automatic t_sample pick_sample(input int neg_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return t_sample'($urandom_range(0, 127));
        else if ($urandom_range(0, 99) < neg_pct)
            return t_sample'(-int'($urandom_range(1, VALUE_BOUND)));
        else
            return t_sample'(int'($urandom_range(0, 2 * VALUE_BOUND)) - VALUE_BOUND);
    endfunction

    function automatic int pick_burst;
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 12);
    endfunction

    // Bursts of beats separated by gaps of varying length
    task automatic send_random(input int n, input int neg_pct);
        int burst;
        int gap;
        burst = pick_burst();
        for (int i = 0; i < n; i++) begin
            put_sample(pick_sample(neg_pct));
            burst--;
            if (burst == 0) begin
                in_valid <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                    gap = $urandom_range(13, 70);
                else
                    gap = $urandom_range(1, 12);
                repeat (gap) @(negedge clk);
                burst = pick_burst();
            end
        end
        stop_sender();
    endtask

    initial begin : stimulus
        int kind;
        int wl;
        int rk;
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_WINDOW_LENGTH;
        cfg_data = '0;
        in_valid = 1'b0;
        sample   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset config: field extremes and clamping of out-of-range codes
        put_sample(t_sample'(-50));
        put_sample(t_sample'(50));
        put_sample(t_sample'(-64));
        put_sample(t_sample'(63));
        put_sample(t_sample'(-51));
        put_sample(t_sample'(51));
        put_sample(t_sample'(0));
        put_sample(t_sample'(-1));
        stop_sender();
        drain();

        // Zero window length and zero rank both act as one
        load_config(t_cfg'(0), t_cfg'(0));
        put_sample(t_sample'(-7));
        put_sample(t_sample'(5));
        stop_sender();
        drain();

        // Short window, second smallest
        load_config(t_cfg'(3), t_cfg'(2));
        put_sample(t_sample'(-10));
        put_sample(t_sample'(-20));
        put_sample(t_sample'(30));
        put_sample(t_sample'(-5));
        put_sample(t_sample'(40));
        stop_sender();
        drain();

        // Rank beyond the number of negatives gives zero
        load_config(t_cfg'(4), t_cfg'(9));
        put_sample(t_sample'(-1));
        put_sample(t_sample'(-2));
        put_sample(t_sample'(-3));
        put_sample(t_sample'(-4));
        stop_sender();
        drain();

        // Oversized window saturates; window not full yet, no beats out
        load_config(t_cfg'(511), t_cfg'(511));
        put_sample(t_sample'(-33));
        put_sample(t_sample'(12));
        put_sample(t_sample'(-49));
        stop_sender();
        drain();

        // Full-size window: fill to the top, then steady state
        load_config(t_cfg'(256), t_cfg'($urandom_range(1, 128)));
        send_random(260, 60);
        drain();

        // Full window, largest rank
        load_config(t_cfg'(256), t_cfg'(256));
        send_random(30, 95);
        drain();

        // Random settings between phases
        for (int p = 0; p < 8; p++) begin
            kind = $urandom_range(0, 5);
            case (kind)
                0: begin
                    wl = $urandom_range(1, 8);
                    rk = $urandom_range(1, wl);
                end
                1: begin
                    wl = $urandom_range(9, 64);
                    rk = $urandom_range(1, wl);
                end
                2: begin
                    wl = 256;
                    rk = $urandom_range(1, 256);
                end
                3: begin
                    wl = $urandom_range(257, 511);
                    rk = $urandom_range(1, 256);
                end
                4: begin
                    wl = $urandom_range(0, 1);
                    rk = $urandom_range(0, 1);
                end
                default: begin
                    wl = $urandom_range(1, 64);
                    rk = $urandom_range(wl + 1, 511);
                end
            endcase
            load_config(t_cfg'(wl), t_cfg'(rk));
            send_random(26, $urandom_range(30, 90));
            drain();
        end

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
